/* rtl/jsu8_pkg.sv */
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by every module under rtl; depends on nothing else.

package jsu8_pkg;

   localparam int COUNT_W    = 25;
   localparam int MAX_W      = 25;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MAX_W-1:0] MAX_OUT_RESET = 25'd1048576;

   // Register index, taken from paddr[2].
   localparam logic REG_MAX_OUT = 1'b0;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SLASH  = 8'h2f;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6e;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;

   localparam logic [5:0] SURR_HIGH_TAG = 6'h36;  // 0xd800..0xdbff
   localparam logic [5:0] SURR_LOW_TAG  = 6'h37;  // 0xdc00..0xdfff

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_STR     = 4'd1,
      MODE_ESC     = 4'd2,
      MODE_HEX     = 4'd3,
      MODE_PAIR_BS = 4'd4,
      MODE_PAIR_U  = 4'd5,
      MODE_LOW     = 4'd6
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_CONTROL   = 3'd1,
      ERR_ESCAPE    = 3'd2,
      ERR_HEX       = 3'd3,
      ERR_SURROGATE = 3'd4,
      ERR_TOO_LONG  = 3'd5,
      ERR_UNTERM    = 3'd6,
      ERR_NO_QUOTE  = 3'd7
   } err_type;

   // One decoded group of results: up to four bytes, or a single status.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      kind_type        kind;
      err_type         err;
   } burst_type;

   // Returns {valid, value} for an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

endpackage

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper producing UTF-8 bytes.
// Depends on jsu8_pkg, jsu8_front, jsu8_queue and jsu8_back.
//
//   Channel   Direction  Transaction carries
//   req_*     in         one raw byte of JSON text, or the end-of-text mark
//   rsp_*     out        one decoded byte, a string-complete mark or an error
//   csr_*     in/out     APB access to max_output_bytes at byte address 0
//
// Plain string bytes stream at one transaction per clock while rsp_tready stays
// high. A Unicode escape that decodes to n bytes keeps the result port busy as
// the emitter sends one result per cycle, and a two-entry group queue absorbs the
// difference before req_tready drops. Reset is synchronous and active high; it
// returns the decoder to idle and the length limit to 1048576. There is no
// clearing pass.

module json_string_unescape_utf8 (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] in_byte
   input  logic                                req_tuser,   // [0] end_of_input

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_byte
   output logic [4:0]                          rsp_tuser,   // [1:0] result_kind, [4:2] fault_code
   output logic                                rsp_tlast,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jsu8_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [jsu8_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [jsu8_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [jsu8_pkg::MAX_W-1:0] max_out_ff, max_out_in;
   logic                       csr_write;

   logic                       push;
   jsu8_pkg::burst_type        push_data;
   logic                       q_full;
   logic                       q_not_empty;
   logic                       q_pop;
   jsu8_pkg::burst_type        q_head;

   // The register file holds just the length limit; the unused address reads zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == jsu8_pkg::REG_MAX_OUT)
                       ? {{(jsu8_pkg::CSR_DATA_W - jsu8_pkg::MAX_W){1'b0}}, max_out_ff}
                       : '0;

   always_comb begin
      max_out_in = max_out_ff;
      if (csr_write && (csr_paddr[2] == jsu8_pkg::REG_MAX_OUT)) begin
         max_out_in = csr_pwdata[jsu8_pkg::MAX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= jsu8_pkg::MAX_OUT_RESET;
      end else begin
         max_out_ff <= max_out_in;
      end
   end

   // The front end may take a byte whenever the queue has room for whatever
   // group that byte produces, even while the emitter is stalled downstream.
   assign req_tready = !q_full;

   jsu8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tuser),
      .max_out  (max_out_ff),
      .push     (push),
      .burst    (push_data)
   );

   jsu8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   jsu8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_user    (rsp_tuser),
      .out_last    (rsp_tlast)
   );

   // A completion or an error is always the only result of its input byte.
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[1:0] != jsu8_pkg::KIND_BYTE)) |-> rsp_tlast)
      else $error("status result without tlast");

   // The error code is zero on anything but an error.
   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[1:0] != jsu8_pkg::KIND_ERR))
      |-> (rsp_tuser[4:2] == jsu8_pkg::ERR_NONE))
      else $error("error code set on a non-error result");

   // A multi-byte group is sent without gaps once it has started.
   a_group_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a decoded byte group");

   // The queue is never written while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("group queue overflow");

endmodule

/* rtl/jsu8_front.sv */
// Front end: accepts raw bytes, runs the escape state machine and builds result groups.
// Depends on jsu8_pkg; feeds jsu8_queue.

module jsu8_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_ready,
   input  logic [7:0]                   in_byte,
   input  logic                         in_end,
   input  logic [jsu8_pkg::MAX_W-1:0]   max_out,
   output logic                         push,
   output jsu8_pkg::burst_type          burst
);

   jsu8_pkg::mode_type mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [9:0]  hh_ff, hh_in;
   logic [jsu8_pkg::COUNT_W-1:0] ocnt_ff, ocnt_in;

   logic        accept;
   logic        idle_mode;
   logic [4:0]  hex;
   logic [15:0] acc_next;
   logic [20:0] cp;
   logic [10:0] plane;
   logic        esc_go;
   logic [2:0]  esc_n;
   logic [3:0][7:0] esc_b;
   logic        fail_go;
   jsu8_pkg::err_type fail_code;
   logic        done_go;
   logic        byte_go;
   logic [jsu8_pkg::COUNT_W:0] total;

   assign accept    = in_valid && in_ready;
   assign idle_mode = (mode_ff == jsu8_pkg::MODE_IDLE) || (mode_ff > jsu8_pkg::MODE_LOW);
   assign hex       = jsu8_pkg::hex_digit(in_byte);
   assign acc_next  = {acc_ff[11:0], hex[3:0]};
   assign plane     = 11'({1'b0, hh_ff} + 11'h040);
   assign cp        = {plane[10:0], acc_next[9:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu8_pkg::MODE_IDLE;
         acc_ff  <= '0;
         dcnt_ff <= '0;
         hh_ff   <= '0;
         ocnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         dcnt_ff <= dcnt_in;
         hh_ff   <= hh_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      dcnt_in   = dcnt_ff;
      hh_in     = hh_ff;
      ocnt_in   = ocnt_ff;
      esc_go    = 1'b0;
      esc_n     = 3'd0;
      esc_b     = '0;
      fail_go   = 1'b0;
      fail_code = jsu8_pkg::ERR_NONE;
      done_go   = 1'b0;
      byte_go   = 1'b0;
      total     = '0;
      push      = 1'b0;
      burst     = '0;

      if (accept) begin
         if (idle_mode) begin
            if (in_end) begin
               fail_go   = 1'b1;
               fail_code = jsu8_pkg::ERR_NO_QUOTE;
            end else if (jsu8_pkg::is_space(in_byte)) begin
               mode_in = jsu8_pkg::MODE_IDLE;
            end else if (in_byte != jsu8_pkg::CHAR_QUOTE) begin
               fail_go   = 1'b1;
               fail_code = jsu8_pkg::ERR_NO_QUOTE;
            end else begin
               mode_in = jsu8_pkg::MODE_STR;
               ocnt_in = '0;
            end
         end else if (in_end) begin
            fail_go   = 1'b1;
            fail_code = jsu8_pkg::ERR_UNTERM;
         end else begin
            unique case (mode_ff) inside
               jsu8_pkg::MODE_STR: begin
                  if (in_byte == jsu8_pkg::CHAR_QUOTE) begin
                     mode_in = jsu8_pkg::MODE_IDLE;
                     done_go = 1'b1;
                  end else if (in_byte < jsu8_pkg::CHAR_SPACE) begin
                     fail_go   = 1'b1;
                     fail_code = jsu8_pkg::ERR_CONTROL;
                  end else if (in_byte == jsu8_pkg::CHAR_BSLASH) begin
                     mode_in = jsu8_pkg::MODE_ESC;
                  end else begin
                     total   = {1'b0, ocnt_ff} + 26'd1;
                     ocnt_in = total[jsu8_pkg::COUNT_W] ? '1 : total[jsu8_pkg::COUNT_W-1:0];
                     byte_go = 1'b1;
                  end
               end
               jsu8_pkg::MODE_ESC: begin
                  esc_go = 1'b1;
                  esc_n  = 3'd1;
                  unique case (in_byte) inside
                     jsu8_pkg::CHAR_QUOTE, jsu8_pkg::CHAR_BSLASH,
                     jsu8_pkg::CHAR_SLASH: esc_b[0] = in_byte;
                     jsu8_pkg::CHAR_LOW_B: esc_b[0] = 8'h08;
                     jsu8_pkg::CHAR_LOW_F: esc_b[0] = 8'h0c;
                     jsu8_pkg::CHAR_LOW_N: esc_b[0] = 8'h0a;
                     jsu8_pkg::CHAR_LOW_R: esc_b[0] = 8'h0d;
                     jsu8_pkg::CHAR_LOW_T: esc_b[0] = 8'h09;
                     jsu8_pkg::CHAR_LOW_U: begin
                        esc_go  = 1'b0;
                        mode_in = jsu8_pkg::MODE_HEX;
                        acc_in  = '0;
                        dcnt_in = '0;
                     end
                     default: begin
                        esc_go    = 1'b0;
                        fail_go   = 1'b1;
                        fail_code = jsu8_pkg::ERR_ESCAPE;
                     end
                  endcase
               end
               jsu8_pkg::MODE_HEX, jsu8_pkg::MODE_LOW: begin
                  if (!hex[4]) begin
                     fail_go   = 1'b1;
                     fail_code = jsu8_pkg::ERR_HEX;
                  end else begin
                     acc_in = acc_next;
                     if (dcnt_ff == 2'd3) begin
                        dcnt_in = '0;
                        if (mode_ff == jsu8_pkg::MODE_HEX) begin
                           if (acc_next[15:10] == jsu8_pkg::SURR_HIGH_TAG) begin
                              hh_in   = acc_next[9:0];
                              mode_in = jsu8_pkg::MODE_PAIR_BS;
                           end else if (acc_next[15:10] == jsu8_pkg::SURR_LOW_TAG) begin
                              fail_go   = 1'b1;
                              fail_code = jsu8_pkg::ERR_SURROGATE;
                           end else if (acc_next[15:7] == 9'd0) begin
                              esc_go   = 1'b1;
                              esc_n    = 3'd1;
                              esc_b[0] = acc_next[7:0];
                           end else if (acc_next[15:11] == 5'd0) begin
                              esc_go   = 1'b1;
                              esc_n    = 3'd2;
                              esc_b[0] = {3'b110, acc_next[10:6]};
                              esc_b[1] = {2'b10, acc_next[5:0]};
                           end else begin
                              esc_go   = 1'b1;
                              esc_n    = 3'd3;
                              esc_b[0] = {4'b1110, acc_next[15:12]};
                              esc_b[1] = {2'b10, acc_next[11:6]};
                              esc_b[2] = {2'b10, acc_next[5:0]};
                           end
                        end else if (acc_next[15:10] != jsu8_pkg::SURR_LOW_TAG) begin
                           fail_go   = 1'b1;
                           fail_code = jsu8_pkg::ERR_SURROGATE;
                        end else begin
                           esc_go   = 1'b1;
                           esc_n    = 3'd4;
                           esc_b[0] = {5'b11110, cp[20:18]};
                           esc_b[1] = {2'b10, cp[17:12]};
                           esc_b[2] = {2'b10, cp[11:6]};
                           esc_b[3] = {2'b10, cp[5:0]};
                        end
                     end else begin
                        dcnt_in = 2'(dcnt_ff + 2'd1);
                     end
                  end
               end
               jsu8_pkg::MODE_PAIR_BS: begin
                  if (in_byte != jsu8_pkg::CHAR_BSLASH) begin
                     fail_go   = 1'b1;
                     fail_code = jsu8_pkg::ERR_SURROGATE;
                  end else begin
                     mode_in = jsu8_pkg::MODE_PAIR_U;
                  end
               end
               jsu8_pkg::MODE_PAIR_U: begin
                  if (in_byte != jsu8_pkg::CHAR_LOW_U) begin
                     fail_go   = 1'b1;
                     fail_code = jsu8_pkg::ERR_SURROGATE;
                  end else begin
                     mode_in = jsu8_pkg::MODE_LOW;
                     acc_in  = '0;
                     dcnt_in = '0;
                  end
               end
               default: begin
                  mode_in = jsu8_pkg::MODE_IDLE;
               end
            endcase
         end

         if (esc_go) begin
            total = {1'b0, ocnt_ff} + 26'(esc_n);
            if (total > {1'b0, max_out}) begin
               fail_go   = 1'b1;
               fail_code = jsu8_pkg::ERR_TOO_LONG;
            end else begin
               ocnt_in        = total[jsu8_pkg::COUNT_W] ? '1 : total[jsu8_pkg::COUNT_W-1:0];
               mode_in        = jsu8_pkg::MODE_STR;
               push           = 1'b1;
               burst.bytes    = esc_b;
               burst.last_idx = 2'(esc_n - 3'd1);
               burst.kind     = jsu8_pkg::KIND_BYTE;
            end
         end

         if (fail_go) begin
            mode_in    = jsu8_pkg::MODE_IDLE;
            push       = 1'b1;
            burst      = '0;
            burst.kind = jsu8_pkg::KIND_ERR;
            burst.err  = fail_code;
         end else if (done_go) begin
            push       = 1'b1;
            burst.kind = jsu8_pkg::KIND_DONE;
         end else if (byte_go) begin
            push           = 1'b1;
            burst.bytes[0] = in_byte;
            burst.kind     = jsu8_pkg::KIND_BYTE;
         end
      end
   end

endmodule

/* rtl/jsu8_queue.sv */
// Two-entry queue of result groups between the front end and the emitter.
// Depends on jsu8_pkg for the group type and depth.

module jsu8_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu8_pkg::burst_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output jsu8_pkg::burst_type head
);

   jsu8_pkg::burst_type entry_ff [jsu8_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'(jsu8_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/jsu8_back.sv */
// Emitter: holds one result group and sends its results one per cycle while out_ready is high.
// Depends on jsu8_pkg; pulls groups from jsu8_queue.

module jsu8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  jsu8_pkg::burst_type q_head,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic [4:0]          out_user,
   output logic                out_last
);

   jsu8_pkg::burst_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       at_end;

   assign at_end    = (idx_ff == cur_ff.last_idx);
   assign out_valid = busy_ff;
   assign out_byte  = cur_ff.bytes[idx_ff];
   assign out_user  = {cur_ff.err, cur_ff.kind};
   assign out_last  = at_end;
   assign q_pop     = q_not_empty && (!busy_ff || (out_ready && at_end));

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_head;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && out_ready) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = 2'(idx_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
